// ===== hdl/esa_pkg.sv =====
// ============================================================================
// esa_pkg
// Shared types and codes of the effect slot allocator: command, status and
// register index codes, the slot entry layout and the controller states.
// ============================================================================
package esa_pkg;

    // field widths
    localparam int CMD_W      = 3;
    localparam int ID_W       = 8;
    localparam int TYPE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int BIDX_W     = 5;
    localparam int POOL_W     = 16;
    localparam int EB_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_AT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FREE_ALL = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_BYTES = 2'd1;

    // reset values of the configuration registers
    localparam logic [POOL_W-1:0] POOL_SIZE_RESET    = 16'd4096;
    localparam logic [EB_W-1:0]   EFFECT_BYTES_RESET = 8'd32;

    // one slot of the table
    typedef struct packed {
        logic              alloc;
        logic              play;
        logic [TYPE_W-1:0] etype;
    } slot_entry_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/esa_ram.sv =====
// ============================================================================
// esa_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered (held while no read is issued).
// ============================================================================
module esa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/esa_slot_store.sv =====
// ============================================================================
// esa_slot_store
// Slot table storage: the entry RAM plus one valid flag per entry, so that
// reset and free-all clear the whole table at once. An entry that was never
// written since the last clear reads as all zero.
// ============================================================================
module esa_slot_store
    import esa_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clr_all,
    input  logic                           rd_en,
    input  logic [$clog2(NUM_SLOTS+1)-1:0] rd_addr,
    output slot_entry_t                    rd_entry,
    input  logic                           wr_en,
    input  logic [$clog2(NUM_SLOTS+1)-1:0] wr_addr,
    input  slot_entry_t                    wr_entry
);

    localparam int DEPTH   = NUM_SLOTS + 1;
    localparam int ENTRY_W = $bits(slot_entry_t);

    logic [DEPTH-1:0]   ent_valid_reg;
    logic               rd_vld_reg;
    logic [ENTRY_W-1:0] ram_rd_data;

    // entry memory
    esa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // valid flags, cleared together on reset and free-all
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (clr_all)
            begin
                ent_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                ent_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= ent_valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the cleared value
    assign rd_entry = rd_vld_reg ? slot_entry_t'(ram_rd_data) : '0;

endmodule

// ===== hdl/effect_slot_allocator_core.sv =====
// ============================================================================
// effect_slot_allocator_core
// Force-feedback effect slot allocator. Slots 1..NUM_SLOTS each hold an
// allocated mark, a playing mark and an effect type in a slot RAM with a
// registered read; a create takes the lowest free slot at or above the
// next-free pointer and charges effect_bytes against a saturating pool
// counter. One command is worked at a time and gives one result item.
// Invalid ids, free-all and unknown commands go straight to the finish
// state; allocate_at, start, stop and free first do one RAM read and one
// write back; create runs the slot scan, which reads one RAM entry per cycle
// from the next-free pointer up to the first free slot after the one taken.
// A new item is accepted as soon as the result is in the output register; a
// result held by the receiver stalls input.
// ============================================================================
module effect_slot_allocator_core
    import esa_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [ID_W-1:0]       slot_id,
    input  logic [TYPE_W-1:0]     effect_type,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [BIDX_W-1:0]     block_index,
    output logic [POOL_W-1:0]     pool_available,
    output logic                  slot_allocated,
    output logic                  slot_playing,
    output logic [TYPE_W-1:0]     slot_type,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W  = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_W  = $clog2(NUM_SLOTS + 2);
    localparam int IDX_W   = (SLOT_W > BIDX_W) ? SLOT_W : BIDX_W;
    localparam int IDC_W   = ID_W + 1;
    localparam int SUM_W   = POOL_W + 1;

    localparam logic [SLOT_W-1:0] ONE_SLOT  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS);
    localparam logic [IDC_W-1:0]  MAX_ID    = IDC_W'(NUM_SLOTS);
    localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);

    // control state
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   next_free_reg, next_free_next;
    logic [IDX_W-1:0]    last_index_reg, last_index_next;
    logic [POOL_W-1:0]   pool_reg, pool_next;
    logic [POOL_W-1:0]   pool_size_reg, pool_size_next;
    logic [EB_W-1:0]     effect_bytes_reg, effect_bytes_next;
    logic                chk_live_reg, chk_live_next;
    logic                phase2_reg, phase2_next;
    logic                out_valid_reg, out_valid_next;

    // working and result payload
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   id_reg, id_next;
    logic [TYPE_W-1:0]   etype_reg, etype_next;
    logic [SLOT_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic [SLOT_W-1:0]   chk_ptr_reg, chk_ptr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    slot_entry_t         res_entry_reg, res_entry_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BIDX_W-1:0]   block_index_reg, block_index_next;
    logic [POOL_W-1:0]   pool_available_reg, pool_available_next;
    slot_entry_t         out_entry_reg, out_entry_next;

    // slot store access
    logic                st_clr;
    logic                st_rd_en;
    logic [ADDR_W-1:0]   st_rd_addr;
    slot_entry_t         st_rd_entry;
    logic                st_wr_en;
    logic [ADDR_W-1:0]   st_wr_addr;
    slot_entry_t         st_wr_entry;

    logic                id_ok;
    logic [SUM_W-1:0]    refund_sum;
    slot_entry_t         mod_entry;

    esa_slot_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_all  (st_clr),
        .rd_en    (st_rd_en),
        .rd_addr  (st_rd_addr),
        .rd_entry (st_rd_entry),
        .wr_en    (st_wr_en),
        .wr_addr  (st_wr_addr),
        .wr_entry (st_wr_entry)
    );

    // slot id range check
    assign id_ok = (slot_id != '0) && ({1'b0, slot_id} <= MAX_ID);

    // pool refund before the ceiling clamp
    assign refund_sum = {1'b0, pool_reg} + SUM_W'(effect_bytes_reg);

    // handshakes
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // next state, store access and datapath
    always_comb
    begin
        state_next          = state_reg;
        next_free_next      = next_free_reg;
        last_index_next     = last_index_reg;
        pool_next           = pool_reg;
        pool_size_next      = pool_size_reg;
        effect_bytes_next   = effect_bytes_reg;
        chk_live_next       = chk_live_reg;
        phase2_next         = phase2_reg;
        out_valid_next      = out_valid_reg;
        cmd_next            = cmd_reg;
        id_next             = id_reg;
        etype_next          = etype_reg;
        scan_ptr_next       = scan_ptr_reg;
        chk_ptr_next        = chk_ptr_reg;
        res_status_next     = res_status_reg;
        res_entry_next      = res_entry_reg;
        status_next         = status_reg;
        block_index_next    = block_index_reg;
        pool_available_next = pool_available_reg;
        out_entry_next      = out_entry_reg;
        st_clr              = 1'b0;
        st_rd_en            = 1'b0;
        st_rd_addr          = '0;
        st_wr_en            = 1'b0;
        st_wr_addr          = '0;
        st_wr_entry         = '0;
        mod_entry           = st_rd_entry;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // register writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POOL_SIZE:    pool_size_next    = cfg_data;
                CFG_EFFECT_BYTES: effect_bytes_next = cfg_data[EB_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    id_next         = slot_id[ADDR_W-1:0];
                    etype_next      = effect_type;
                    res_status_next = STAT_OK;
                    res_entry_next  = '0;
                    state_next      = ST_FINISH;
                    unique case (command) inside
                        CMD_CREATE:
                        begin
                            scan_ptr_next = next_free_reg;
                            chk_live_next = 1'b0;
                            phase2_next   = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        CMD_ALLOC_AT, CMD_START, CMD_STOP, CMD_FREE:
                        begin
                            if (id_ok)
                            begin
                                st_rd_en   = 1'b1;
                                st_rd_addr = slot_id[ADDR_W-1:0];
                                state_next = ST_MODIFY;
                            end
                            else
                            begin
                                res_status_next = STAT_INVALID;
                            end
                        end
                        CMD_FREE_ALL:
                        begin
                            st_clr         = 1'b1;
                            next_free_next = ONE_SLOT;
                            pool_next      = pool_size_reg;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle until past the last slot
                if (scan_ptr_reg <= LAST_SLOT)
                begin
                    st_rd_en      = 1'b1;
                    st_rd_addr    = scan_ptr_reg[ADDR_W-1:0];
                    scan_ptr_next = scan_ptr_reg + ONE_SLOT;
                end
                chk_ptr_next  = scan_ptr_reg;
                chk_live_next = 1'b1;

                // examine the entry read last cycle
                if (chk_live_reg)
                begin
                    if (!phase2_reg)
                    begin
                        if (chk_ptr_reg > LAST_SLOT)
                        begin
                            // no free slot left
                            res_status_next = STAT_FULL;
                            last_index_next = '0;
                            state_next      = ST_FINISH;
                        end
                        else if (!st_rd_entry.alloc)
                        begin
                            // take this slot, then keep scanning for the pointer
                            st_wr_en          = 1'b1;
                            st_wr_addr        = chk_ptr_reg[ADDR_W-1:0];
                            st_wr_entry.alloc = 1'b1;
                            st_wr_entry.play  = 1'b0;
                            st_wr_entry.etype = etype_reg;
                            res_entry_next    = st_wr_entry;
                            last_index_next   = IDX_W'(chk_ptr_reg);
                            pool_next         = (pool_reg > POOL_W'(effect_bytes_reg)) ?
                                                (pool_reg - POOL_W'(effect_bytes_reg)) : '0;
                            phase2_next       = 1'b1;
                        end
                    end
                    else if ((chk_ptr_reg > LAST_SLOT) || !st_rd_entry.alloc)
                    begin
                        next_free_next = chk_ptr_reg;
                        state_next     = ST_FINISH;
                    end
                end
            end

            ST_MODIFY:
            begin
                // read-modify-write of the addressed slot
                case (cmd_reg)
                    CMD_ALLOC_AT:
                    begin
                        mod_entry.alloc = 1'b1;
                        mod_entry.play  = 1'b0;
                        mod_entry.etype = '0;
                    end
                    CMD_START:
                    begin
                        mod_entry.play = 1'b1;
                    end
                    CMD_STOP:
                    begin
                        mod_entry.play = 1'b0;
                    end
                    CMD_FREE:
                    begin
                        mod_entry.alloc = 1'b0;
                        mod_entry.play  = 1'b0;
                        if (SLOT_W'(id_reg) < next_free_reg)
                        begin
                            next_free_next = SLOT_W'(id_reg);
                        end
                        // refund, clamped at the pool size
                        if (pool_reg < pool_size_reg)
                        begin
                            pool_next = (refund_sum > {1'b0, pool_size_reg}) ?
                                        pool_size_reg : refund_sum[POOL_W-1:0];
                        end
                    end
                    default: ;
                endcase
                st_wr_en       = 1'b1;
                st_wr_addr     = id_reg;
                st_wr_entry    = mod_entry;
                res_entry_next = mod_entry;
                state_next     = ST_FINISH;
            end

            ST_FINISH:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = res_status_reg;
                    block_index_next    = last_index_reg[BIDX_W-1:0];
                    pool_available_next = pool_reg;
                    out_entry_next      = res_entry_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg    <= ONE_SLOT;
            last_index_reg   <= IDX_ONE;
            pool_reg         <= POOL_SIZE_RESET;
            pool_size_reg    <= POOL_SIZE_RESET;
            effect_bytes_reg <= EFFECT_BYTES_RESET;
            chk_live_reg     <= 1'b0;
            phase2_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            next_free_reg    <= next_free_next;
            last_index_reg   <= last_index_next;
            pool_reg         <= pool_next;
            pool_size_reg    <= pool_size_next;
            effect_bytes_reg <= effect_bytes_next;
            chk_live_reg     <= chk_live_next;
            phase2_reg       <= phase2_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg            <= cmd_next;
        id_reg             <= id_next;
        etype_reg          <= etype_next;
        scan_ptr_reg       <= scan_ptr_next;
        chk_ptr_reg        <= chk_ptr_next;
        res_status_reg     <= res_status_next;
        res_entry_reg      <= res_entry_next;
        status_reg         <= status_next;
        block_index_reg    <= block_index_next;
        pool_available_reg <= pool_available_next;
        out_entry_reg      <= out_entry_next;
    end

    // result outputs
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign block_index    = block_index_reg;
    assign pool_available = pool_available_reg;
    assign slot_allocated = out_entry_reg.alloc;
    assign slot_playing   = out_entry_reg.play;
    assign slot_type      = out_entry_reg.etype;

`ifndef SYNTHESIS
    // next-free pointer stays within 1..NUM_SLOTS+1
    a_next_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != '0) && (next_free_reg <= SLOT_W'(NUM_SLOTS + 1)))
        else $error("next-free pointer out of range");

    // slot zero is never written
    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> (st_wr_addr != '0))
        else $error("write to slot zero");

    // a full create reports block index zero
    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_FULL)) |-> (block_index == '0))
        else $error("full status with nonzero block index");

    // an accepted item always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("item accepted without leaving idle");
`endif

endmodule

// ===== tb/sv/effect_slot_allocator_core_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// effect_slot_allocator_core_test
// Self-checking bench for the effect slot allocator. Commands are driven on
// the item channel with random gaps, and the result channel stalls at random.
// A scoreboard class keeps its own copy of the slot table and pool counter
// and checks every result item in order. Each phase writes both registers
// while the block is idle, then issues a fill run of creates and a mix of
// random commands, invalid ids and unused codes.
// ============================================================================
import esa_pkg::*;

// one result item, laid out as the block's result ports
typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   block_index;
    logic [POOL_W-1:0]   pool_available;
    logic                slot_allocated;
    logic                slot_playing;
    logic [TYPE_W-1:0]   slot_type;
} slot_result_t;

class slot_scoreboard #(int SLOTS = 16);

    // slot table, index 0 unused
    bit                alloc_mark [SLOTS+1];
    bit                play_mark [SLOTS+1];
    logic [TYPE_W-1:0] stored_type [SLOTS+1];
    int                next_free;
    int                pool_count;
    int                last_index;
    int                pool_size;
    int                effect_bytes;

    slot_result_t      pending [$];
    int                error_count;

    function new();
        for (int i = 0; i <= SLOTS; i++)
        begin
            alloc_mark[i]  = 1'b0;
            play_mark[i]   = 1'b0;
            stored_type[i] = '0;
        end
        next_free    = 1;
        pool_size    = POOL_SIZE_RESET;
        effect_bytes = EFFECT_BYTES_RESET;
        pool_count   = POOL_SIZE_RESET;
        last_index   = 1;
        error_count  = 0;
    endfunction

    // register write seen on the configuration channel
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_POOL_SIZE)
            pool_size = data;
        else if (idx == CFG_EFFECT_BYTES)
            effect_bytes = data[EB_W-1:0];
    endfunction

    // lowest unallocated slot at or above from, SLOTS+1 when none
    function int first_free(int from);
        int s;
        s = (from < 1) ? 1 : from;
        while (s <= SLOTS && alloc_mark[s])
            s++;
        return (s > SLOTS) ? SLOTS + 1 : s;
    endfunction

    // accepted command item: update the table and queue the expected result
    function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [TYPE_W-1:0] etype);
        slot_result_t want;
        int           target;
        int           s;
        int           sum;
        bit           id_ok;
        want   = '0;
        target = 0;
        id_ok  = (id >= 1 && id <= SLOTS);
        want.status = STAT_OK;
        case (cmd)
            CMD_CREATE:
            begin
                s = first_free(next_free);
                if (s > SLOTS)
                begin
                    want.status = STAT_FULL;
                    last_index  = 0;
                end
                else
                begin
                    alloc_mark[s]  = 1'b1;
                    play_mark[s]   = 1'b0;
                    stored_type[s] = etype;
                    next_free      = first_free(s + 1);
                    pool_count     = (pool_count > effect_bytes) ? pool_count - effect_bytes : 0;
                    last_index     = s;
                    target         = s;
                end
            end
            CMD_ALLOC_AT, CMD_START, CMD_STOP, CMD_FREE:
            begin
                if (!id_ok)
                    want.status = STAT_INVALID;
                else
                begin
                    target = id;
                    case (cmd)
                        CMD_ALLOC_AT:
                        begin
                            alloc_mark[id]  = 1'b1;
                            play_mark[id]   = 1'b0;
                            stored_type[id] = '0;
                        end
                        CMD_START:
                            play_mark[id] = 1'b1;
                        CMD_STOP:
                            play_mark[id] = 1'b0;
                        default:
                        begin
                            // free keeps the stored type, refund saturates at pool_size
                            alloc_mark[id] = 1'b0;
                            play_mark[id]  = 1'b0;
                            if (id < next_free)
                                next_free = id;
                            if (pool_count < pool_size)
                            begin
                                sum        = pool_count + effect_bytes;
                                pool_count = (sum > pool_size) ? pool_size : sum;
                            end
                        end
                    endcase
                end
            end
            CMD_FREE_ALL:
            begin
                for (int i = 0; i <= SLOTS; i++)
                begin
                    alloc_mark[i]  = 1'b0;
                    play_mark[i]   = 1'b0;
                    stored_type[i] = '0;
                end
                next_free  = 1;
                pool_count = pool_size;
            end
            default:
                ;
        endcase
        want.block_index    = last_index[BIDX_W-1:0];
        want.pool_available = pool_count[POOL_W-1:0];
        if (target != 0)
        begin
            want.slot_allocated = alloc_mark[target];
            want.slot_playing   = play_mark[target];
            want.slot_type      = stored_type[target];
        end
        pending.push_back(want);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // accepted result item: compare against the oldest expectation
    function void check_result(slot_result_t got);
        slot_result_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: result item with nothing expected, actual status %0d index %0d pool %0d",
                     $time, got.status, got.block_index, got.pool_available);
            error_count++;
            return;
        end
        want = pending.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("block_index", want.block_index, got.block_index);
        compare_field("pool_available", want.pool_available, got.pool_available);
        compare_field("slot_allocated", want.slot_allocated, got.slot_allocated);
        compare_field("slot_playing", want.slot_playing, got.slot_playing);
        compare_field("slot_type", want.slot_type, got.slot_type);
    endfunction

endclass

module effect_slot_allocator_core_test;

    localparam int SLOTS        = 16;
    localparam int STALL_LIMIT  = 3000;
    localparam int BACKLOG_AT   = 400;
    localparam int BACKLOG_HOLD = 300;

    // command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CMD_W-1:0]      command;
    logic [ID_W-1:0]       slot_id;
    logic [TYPE_W-1:0]     effect_type;
    logic                  out_valid;
    logic                  out_ready;
    logic [STATUS_W-1:0]   status;
    logic [BIDX_W-1:0]     block_index;
    logic [POOL_W-1:0]     pool_available;
    logic                  slot_allocated;
    logic                  slot_playing;
    logic [TYPE_W-1:0]     slot_type;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slot_scoreboard #(SLOTS) sb;
    bit idling;
    int results_checked = 0;
    int stall_cycles = 0;

    effect_slot_allocator_core #(
        .NUM_SLOTS(SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .slot_id       (slot_id),
        .effect_type   (effect_type),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_index   (block_index),
        .pool_available(pool_available),
        .slot_allocated(slot_allocated),
        .slot_playing  (slot_playing),
        .slot_type     (slot_type),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        slot_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status         = status;
            got.block_index    = block_index;
            got.pool_available = pool_available;
            got.slot_allocated = slot_allocated;
            got.slot_playing   = slot_playing;
            got.slot_type      = slot_type;
            sb.check_result(got);
            results_checked++;
        end
    end

    // cycles since the last handshake on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("effect_slot_allocator_core regression: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off to back up the block
    initial
    begin : result_ready_driver
        bit backlog_done;
        backlog_done = 1'b0;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!backlog_done && results_checked >= BACKLOG_AT)
            begin
                backlog_done = 1'b1;
                out_ready <= 1'b0;
                repeat (BACKLOG_HOLD) @(negedge clk);
            end
            else if (idling && $urandom_range(3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // one command item, entered and left at a falling edge; valid stays high
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                logic [TYPE_W-1:0] etype);
        if (idling && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        slot_id     <= id;
        effect_type <= etype;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(cmd, id, etype);
        @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, data);
        @(negedge clk);
    endtask

    // stop offering commands and wait for every expected result
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    // mostly valid ids, sometimes zero or above the table
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 85)
            return ID_W'($urandom_range(1, SLOTS));
        else if ($urandom_range(3) == 0)
            return '0;
        else
            return ID_W'($urandom_range(SLOTS + 1, 255));
    endfunction

    task automatic send_random_command();
        int pick;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 38)
            cmd = CMD_CREATE;
        else if (pick < 46)
            cmd = CMD_ALLOC_AT;
        else if (pick < 58)
            cmd = CMD_START;
        else if (pick < 68)
            cmd = CMD_STOP;
        else if (pick < 90)
            cmd = CMD_FREE;
        else if (pick < 93)
            cmd = CMD_FREE_ALL;
        else if (pick < 96)
            cmd = CMD_UNUSED_LO;
        else
            cmd = CMD_UNUSED_HI;
        send_command(cmd, pick_id(), TYPE_W'($urandom_range(255)));
    endtask

    // write both registers while idle, then a fill run and random commands
    task automatic run_phase(int pool_bytes, int charge, bit clear_first, int count);
        settle();
        if ($urandom_range(1))
        begin
            write_register(CFG_POOL_SIZE, CFG_DATA_W'(pool_bytes));
            write_register(CFG_EFFECT_BYTES, CFG_DATA_W'(charge));
        end
        else
        begin
            write_register(CFG_EFFECT_BYTES, CFG_DATA_W'(charge));
            write_register(CFG_POOL_SIZE, CFG_DATA_W'(pool_bytes));
        end
        cfg_valid <= 1'b0;
        if (clear_first)
            send_command(CMD_FREE_ALL, ID_W'($urandom_range(255)), TYPE_W'($urandom_range(255)));
        // enough creates to run the table full
        repeat (SLOTS + 2)
            send_command(CMD_CREATE, ID_W'($urandom_range(255)), TYPE_W'($urandom_range(255)));
        repeat (count - SLOTS - 3)
            send_random_command();
    endtask

    task automatic directed_checks();
        send_command(CMD_CREATE, 8'd0, 8'hff);
        send_command(CMD_ALLOC_AT, ID_W'(SLOTS), 8'h00);
        send_command(CMD_START, ID_W'(SLOTS), 8'h5a);
        send_command(CMD_STOP, ID_W'(SLOTS), 8'ha5);
        // start and free of a slot that was never allocated
        send_command(CMD_START, 8'd5, 8'h00);
        send_command(CMD_FREE, 8'd5, 8'h00);
        // refund with the pool already at the ceiling
        send_command(CMD_FREE, 8'd1, 8'h00);
        send_command(CMD_CREATE, 8'hff, 8'h00);
        send_command(CMD_CREATE, 8'h80, 8'h81);
        // invalid ids
        send_command(CMD_START, 8'd0, 8'h00);
        send_command(CMD_ALLOC_AT, ID_W'(SLOTS + 1), 8'h00);
        send_command(CMD_FREE, 8'hff, 8'hff);
        send_command(CMD_STOP, 8'h80, 8'h00);
        send_command(CMD_FREE, 8'd0, 8'h00);
        // unused command codes
        send_command(CMD_UNUSED_LO, 8'd2, 8'h33);
        send_command(CMD_UNUSED_HI, 8'd3, 8'hcc);
        send_command(CMD_FREE_ALL, 8'd7, 8'h00);
        send_command(CMD_CREATE, 8'd1, 8'h7e);
    endtask

    initial
    begin
        sb = new();
        idling      = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = '0;
        slot_id     = '0;
        effect_type = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_checks();
        run_phase(65535, 255, 1'b1, 205);
        // pool size below the current count, then zero pool
        run_phase(0, 1, 1'b0, 205);
        run_phase(100, 255, 1'b1, 205);
        run_phase(1000, 1, 1'b0, 205);
        run_phase($urandom_range(65535), $urandom_range(1, 255), 1'($urandom_range(1)), 205);
        // last part runs without gaps or stalls
        idling = 1'b0;
        run_phase(600, 37, 1'b1, 205);

        settle();
        repeat (SLOTS + 10) @(negedge clk);
        if (sb.error_count == 0 && sb.pending.size() == 0)
            $display("effect_slot_allocator_core regression: pass");
        else
            $display("effect_slot_allocator_core regression: fail");
        $finish;
    end

endmodule
